// File: hw/rtl/qdof_pkg.sv
// Shared types and constants for the quote driven order fill block.
// Used by the controller, the datapath and the top level; no dependencies.
package qdof_pkg;

  localparam int RowLimit = 64;
  localparam int RowW     = 7;

  // One stored limit order
  typedef struct packed {
    logic [30:0] id;
    logic [7:0]  symbol;
    logic        side;
    logic [31:0] limit;
    logic [30:0] remaining;
    logic        reported;
  } ent_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // latch the input transaction
    logic clr;         // clear one fill-sum row of the new entry
    logic commit;      // write the new entry, bump the count
    logic ent_rd;      // read entry at walk index
    logic nxt;         // advance walk index
    logic fill_start;  // register fill size, read sums at quote exchange
    logic fill_mul;    // register price times fill
    logic fill_wr;     // write back sums and remaining quantity
    logic rep_rd;      // read sums for one report row
    logic rep_row;     // capture one report row
    logic flush;       // send held row out as final
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_add;
    logic full;
    logic walk_end;
    logic match;
    logic rem_zero;
    logic rep_ok;
    logic fill_ok;
    logic x_last;
    logic push_ok;
    logic flush_ok;
  } sts_t;

endpackage

// File: hw/rtl/qdof_ctrl.sv
// Sequencer for add and quote transactions of the order fill block.
// Depends on qdof_pkg; drives the datapath through cmd_t, reads sts_t.
module qdof_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  qdof_pkg::sts_t sts,
  output qdof_pkg::cmd_t cmd
);
  import qdof_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_ACLR  = 9'b000000010,
    S_QRD   = 9'b000000100,
    S_QEV   = 9'b000001000,
    S_FMUL  = 9'b000010000,
    S_FWR   = 9'b000100000,
    S_RRD   = 9'b001000000,
    S_RROW  = 9'b010000000,
    S_FLUSH = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (!sts.is_add)   state_next = S_QRD;
          else if (!sts.full) state_next = S_ACLR;
        end
      end
      S_ACLR: begin
        cmd.clr = 1'b1;
        if (sts.x_last) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_QRD: begin
        if (sts.walk_end) state_next = S_FLUSH;
        else begin
          cmd.ent_rd = 1'b1;
          state_next = S_QEV;
        end
      end
      S_QEV: begin
        priority if (!sts.match) begin
          cmd.nxt = 1'b1;
          state_next = S_QRD;
        end else if (sts.rem_zero) begin
          if (sts.rep_ok) state_next = S_RRD;
          else begin
            cmd.nxt = 1'b1;
            state_next = S_QRD;
          end
        end else if (sts.fill_ok) begin
          cmd.fill_start = 1'b1;
          state_next = S_FMUL;
        end else begin
          cmd.nxt = 1'b1;
          state_next = S_QRD;
        end
      end
      S_FMUL: begin
        cmd.fill_mul = 1'b1;
        state_next = S_FWR;
      end
      S_FWR: begin
        cmd.fill_wr = 1'b1;
        cmd.nxt     = 1'b1;
        state_next  = S_QRD;
      end
      S_RRD: begin
        cmd.rep_rd = 1'b1;
        state_next = S_RROW;
      end
      S_RROW: begin
        if (sts.push_ok) begin
          cmd.rep_row = 1'b1;
          if (sts.x_last) begin
            cmd.nxt = 1'b1;
            state_next = S_QRD;
          end else begin
            state_next = S_RRD;
          end
        end
      end
      S_FLUSH: begin
        if (sts.flush_ok) begin
          cmd.flush = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/qdof_dp.sv
// Datapath: order table, per-exchange fill sums, fill arithmetic and row output.
// Depends on qdof_pkg; controlled by qdof_ctrl through cmd_t and sts_t.
module qdof_dp #(
  parameter int MAX_ORDERS    = 16,
  parameter int NUM_EXCHANGES = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  qdof_pkg::cmd_t cmd,
  output qdof_pkg::sts_t sts,
  input  logic           mode,
  input  logic           side,
  input  logic [7:0]     symbol_index,
  input  logic [1:0]     exchange_index,
  input  logic [30:0]    order_id,
  input  logic [31:0]    price,
  input  logic [30:0]    amount,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [30:0]    report_order_id,
  output logic [7:0]     report_symbol,
  output logic [1:0]     report_exchange,
  output logic [30:0]    filled_quantity,
  output logic [62:0]    filled_notional,
  output logic           last
);
  import qdof_pkg::*;

  localparam int IW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
  localparam int CW = $clog2(MAX_ORDERS + 1);
  localparam int XW = (NUM_EXCHANGES > 1) ? $clog2(NUM_EXCHANGES) : 1;
  localparam int SD = MAX_ORDERS * NUM_EXCHANGES;
  localparam int AW = (SD > 1) ? $clog2(SD) : 1;

  // Latched transaction
  logic          it_mode, it_side;
  logic [7:0]    it_sym;
  logic [1:0]    it_exch;
  logic [30:0]   it_id;
  logic [31:0]   it_price;
  logic [30:0]   qleft;

  logic [CW-1:0] count, e;
  logic [XW-1:0] x;
  logic [RowW-1:0] rows;

  // Order table and fill sums
  ent_t        ent_mem [MAX_ORDERS];
  ent_t        ent_q;
  logic [30:0] qsum_mem [SD];
  logic [62:0] vsum_mem [SD];
  logic [30:0] qsum_q;
  logic [62:0] vsum_q;

  logic [30:0] f;
  logic [62:0] prod;

  // Held row, emitted once it is known whether it is the final one
  logic        pend_valid;
  logic [30:0] pend_id;
  logic [7:0]  pend_sym;
  logic [1:0]  pend_x;
  logic [30:0] pend_qty;
  logic [62:0] pend_val;

  logic          x_last, exch_ok, cross_ok, push;
  logic [30:0]   f_calc;
  logic [XW-1:0] ex_x;
  logic          ent_we, sum_we, sum_re;
  logic [IW-1:0] ent_wa;
  ent_t          ent_wd;
  logic [AW-1:0] sum_wa, sum_ra;
  logic [30:0]   qsum_wd;
  logic [62:0]   vsum_wd;

  function automatic logic [AW-1:0] sum_addr(input logic [IW-1:0] idx,
                                             input logic [XW-1:0] xx);
    sum_addr = AW'(AW'(idx) * AW'(NUM_EXCHANGES) + AW'(xx));
  endfunction

  assign x_last   = (32'(x) == NUM_EXCHANGES - 1);
  assign exch_ok  = (32'(it_exch) < NUM_EXCHANGES);
  assign ex_x     = XW'(it_exch);
  assign cross_ok = it_side ? (it_price >= ent_q.limit) : (it_price <= ent_q.limit);
  assign f_calc   = (qleft < ent_q.remaining) ? qleft : ent_q.remaining;
  assign push     = pend_valid && (cmd.rep_row || cmd.flush);

  // Status toward the controller
  always_comb begin
    sts.is_add   = ~mode;
    sts.full     = (32'(count) >= MAX_ORDERS);
    sts.walk_end = (e == count);
    sts.match    = (ent_q.symbol == it_sym) && (ent_q.side == it_side);
    sts.rem_zero = (ent_q.remaining == '0);
    sts.rep_ok   = !ent_q.reported && (32'(rows) + NUM_EXCHANGES <= RowLimit);
    sts.fill_ok  = exch_ok && cross_ok && (f_calc != '0);
    sts.x_last   = x_last;
    sts.push_ok  = !pend_valid || !out_valid || out_ready;
    sts.flush_ok = !pend_valid || !out_valid || out_ready;
  end

  // Write and read port selection
  always_comb begin
    ent_we = cmd.commit || cmd.fill_wr || (cmd.rep_row && x_last);
    ent_wa = cmd.commit ? count[IW-1:0] : e[IW-1:0];
    ent_wd = ent_q;
    if (cmd.commit) begin
      ent_wd.id        = it_id;
      ent_wd.symbol    = it_sym;
      ent_wd.side      = it_side;
      ent_wd.limit     = it_price;
      ent_wd.remaining = qleft;
      ent_wd.reported  = 1'b0;
    end else if (cmd.fill_wr) begin
      ent_wd.remaining = ent_q.remaining - f;
    end else begin
      ent_wd.reported  = 1'b1;
    end
    sum_we  = cmd.clr || cmd.fill_wr;
    sum_wa  = cmd.clr ? sum_addr(count[IW-1:0], x) : sum_addr(e[IW-1:0], ex_x);
    qsum_wd = cmd.clr ? '0 : qsum_q + f;
    vsum_wd = cmd.clr ? '0 : vsum_q + prod;
    sum_re  = cmd.fill_start || cmd.rep_rd;
    sum_ra  = cmd.fill_start ? sum_addr(e[IW-1:0], ex_x) : sum_addr(e[IW-1:0], x);
  end

  // Memories
  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    if (cmd.ent_rd) ent_q <= ent_mem[e[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      qsum_mem[sum_wa] <= qsum_wd;
      vsum_mem[sum_wa] <= vsum_wd;
    end
    if (sum_re) begin
      qsum_q <= qsum_mem[sum_ra];
      vsum_q <= vsum_mem[sum_ra];
    end
  end

  // Transaction latch and fill arithmetic
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_mode  <= mode;
      it_side  <= side;
      it_sym   <= symbol_index;
      it_exch  <= exchange_index;
      it_id    <= order_id;
      it_price <= price;
      qleft    <= amount;
    end else if (cmd.fill_wr) begin
      qleft    <= qleft - f;
    end
    if (cmd.fill_start) f <= f_calc;
    if (cmd.fill_mul)   prod <= 63'(it_price) * 63'(f);
  end

  // Counters
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      e     <= '0;
      x     <= '0;
      rows  <= '0;
    end else begin
      if (cmd.commit) count <= count + 1'b1;
      if (cmd.load) begin
        e    <= '0;
        x    <= '0;
        rows <= '0;
      end else begin
        if (cmd.nxt) e <= e + 1'b1;
        if (cmd.clr || cmd.rep_row) x <= x_last ? '0 : x + 1'b1;
        if (cmd.rep_row) rows <= rows + 1'b1;
      end
    end
  end

  // Held row and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.rep_row)    pend_valid <= 1'b1;
      else if (cmd.flush) pend_valid <= 1'b0;
      if (push)           out_valid  <= 1'b1;
      else if (out_ready) out_valid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rep_row) begin
      pend_id  <= ent_q.id;
      pend_sym <= ent_q.symbol;
      pend_x   <= 2'(x);
      pend_qty <= qsum_q;
      pend_val <= vsum_q;
    end
    if (push) begin
      report_order_id <= pend_id;
      report_symbol   <= pend_sym;
      report_exchange <= pend_x;
      filled_quantity <= pend_qty;
      filled_notional <= pend_val;
      last            <= cmd.flush && !it_mode ? 1'b0 : cmd.flush;
    end
  end

endmodule

// File: hw/rtl/quote_driven_order_fill.sv
// Quote driven order fill: add orders to a table, fill them from quotes.
// Add transaction: clears the new entry's fill sums for each exchange, writes it with the last.
// Quote transaction: walks the order table, filling crossing entries from the quote and
//   emitting report rows for filled ones, then sends the held row out as final.
// Results leave through one output register; the next transaction is taken while it waits.
// Reset (rst, synchronous) empties the table; no clearing pass is needed.
module quote_driven_order_fill #(
  parameter int MAX_ORDERS    = 16,
  parameter int NUM_EXCHANGES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic        side,
  input  logic [7:0]  symbol_index,
  input  logic [1:0]  exchange_index,
  input  logic [30:0] order_id,
  input  logic [31:0] price,
  input  logic [30:0] amount,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [30:0] report_order_id,
  output logic [7:0]  report_symbol,
  output logic [1:0]  report_exchange,
  output logic [30:0] filled_quantity,
  output logic [62:0] filled_notional,
  output logic        last
);
  import qdof_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  qdof_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table, sums and output
  qdof_dp #(
    .MAX_ORDERS    (MAX_ORDERS),
    .NUM_EXCHANGES (NUM_EXCHANGES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .mode            (mode),
    .side            (side),
    .symbol_index    (symbol_index),
    .exchange_index  (exchange_index),
    .order_id        (order_id),
    .price           (price),
    .amount          (amount),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .report_order_id (report_order_id),
    .report_symbol   (report_symbol),
    .report_exchange (report_exchange),
    .filled_quantity (filled_quantity),
    .filled_notional (filled_notional),
    .last            (last)
  );

endmodule

// File: hw/rtl/qdof_chk.sv
// Port-level checks for the quote driven order fill block.
// Attached to quote_driven_order_fill by the bind statement at the end.
module qdof_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [30:0] report_order_id,
  input logic [62:0] filled_notional,
  input logic        last
);

  // Stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(report_order_id)
      && $stable(filled_notional) && $stable(last))
    else $error("stalled result changed");

  // No result appears the cycle after a transaction is taken
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared right after accept");

  // Nothing is offered right out of reset
  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind quote_driven_order_fill qdof_chk u_chk (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .report_order_id (report_order_id),
  .filled_notional (filled_notional),
  .last            (last)
);

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench for quote_driven_order_fill: directed table, then random orders and quotes.
// Rows are checked against an in-bench order book model; depends on qdof_pkg and the RTL.
module tb;
  import qdof_pkg::*;

  localparam int NumOrders = 16;
  localparam int NumExch   = 4;
  localparam int RandItems = 350;
  localparam int IdleLimit = 20000;

  typedef struct {
    logic [30:0] id;
    logic [7:0]  sym;
    logic [1:0]  exch;
    logic [30:0] qty;
    logic [62:0] notional;
    logic        last;
  } fill_row_t;

  typedef struct {
    logic        mode;
    logic        side;
    logic [7:0]  sym;
    logic [1:0]  exch;
    logic [30:0] id;
    logic [31:0] price;
    logic [30:0] amount;
    int          rows;   // typed row count, or -1 to trust the book model
  } order_txn_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic mode = 1'b0;
  logic side = 1'b0;
  logic [7:0] symbol_index = '0;
  logic [1:0] exchange_index = '0;
  logic [30:0] order_id = '0;
  logic [31:0] price = '0;
  logic [30:0] amount = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [30:0] report_order_id;
  logic [7:0] report_symbol;
  logic [1:0] report_exchange;
  logic [30:0] filled_quantity;
  logic [62:0] filled_notional;
  logic last;

  // Book model state
  int          book_count;
  logic [30:0] book_id [NumOrders];
  logic [7:0]  book_sym [NumOrders];
  logic        book_side [NumOrders];
  logic [31:0] book_limit [NumOrders];
  logic [30:0] book_left [NumOrders];
  logic        book_reported [NumOrders];
  logic [30:0] book_qty_sum [NumOrders][NumExch];
  logic [62:0] book_value_sum [NumOrders][NumExch];

  fill_row_t pending_rows[$];
  int errors = 0;
  int idle_cycles = 0;
  int ready_mode = 0;
  int ready_tick = 0;

  quote_driven_order_fill i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .side(side), .symbol_index(symbol_index),
    .exchange_index(exchange_index), .order_id(order_id),
    .price(price), .amount(amount),
    .out_valid(out_valid), .out_ready(out_ready),
    .report_order_id(report_order_id), .report_symbol(report_symbol),
    .report_exchange(report_exchange), .filled_quantity(filled_quantity),
    .filled_notional(filled_notional), .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one transaction to the book model and queue the report rows it causes
  function automatic int book_apply(order_txn_t t);
    int n;
    int first;
    logic [30:0] qleft;
    logic [30:0] f;
    logic        crosses;
    fill_row_t   r;
    n = 0;
    first = pending_rows.size();
    if (!t.mode) begin
      if (book_count < NumOrders) begin
        book_id[book_count] = t.id;
        book_sym[book_count] = t.sym;
        book_side[book_count] = t.side;
        book_limit[book_count] = t.price;
        book_left[book_count] = t.amount;
        book_reported[book_count] = 1'b0;
        for (int x = 0; x < NumExch; x++) begin
          book_qty_sum[book_count][x] = '0;
          book_value_sum[book_count][x] = '0;
        end
        book_count++;
      end
      return 0;
    end
    qleft = t.amount;
    for (int e = 0; e < book_count; e++) begin
      if (book_sym[e] != t.sym || book_side[e] != t.side) continue;
      if (book_left[e] == 0) begin
        if (!book_reported[e] && n + NumExch <= RowLimit) begin
          for (int x = 0; x < NumExch; x++) begin
            r.id = book_id[e];
            r.sym = book_sym[e];
            r.exch = 2'(x);
            r.qty = book_qty_sum[e][x];
            r.notional = book_value_sum[e][x];
            r.last = 1'b0;
            pending_rows = {pending_rows, r};
            n++;
          end
          book_reported[e] = 1'b1;
        end
        continue;
      end
      if (int'(t.exch) >= NumExch) continue;
      crosses = t.side ? (t.price >= book_limit[e]) : (t.price <= book_limit[e]);
      if (!crosses) continue;
      f = (qleft < book_left[e]) ? qleft : book_left[e];
      if (f == 0) continue;
      qleft -= f;
      book_left[e] -= f;
      book_qty_sum[e][t.exch] += f;
      book_value_sum[e][t.exch] += 63'(t.price) * 63'(f);
    end
    if (n > 0) pending_rows[first + n - 1].last = 1'b1;
    return n;
  endfunction

  // Present one transaction and hold it until the block takes it
  task automatic send_order(order_txn_t t);
    int n;
    in_valid <= 1'b1;
    mode <= t.mode;
    side <= t.side;
    symbol_index <= t.sym;
    exchange_index <= t.exch;
    order_id <= t.id;
    price <= t.price;
    amount <= t.amount;
    do @(negedge clk); while (!in_ready);
    n = book_apply(t);
    if (t.rows >= 0 && n != t.rows) begin
      $display("%0t: row count mismatch exp %0d act %0d", $time, t.rows, n);
      errors++;
    end
    @(posedge clk);
  endtask

  // Pick a random transaction, biased toward a few busy symbols
  function automatic order_txn_t random_order();
    order_txn_t t;
    int pick;
    t.mode = ($urandom_range(0, 9) < 7);
    t.side = 1'($urandom);
    pick = $urandom_range(0, 9);
    t.sym = (pick < 3) ? 8'd9 : (pick < 6) ? 8'd42 : (pick < 8) ? 8'd255 : 8'($urandom);
    t.exch = 2'($urandom);
    t.id = 31'($urandom);
    t.price = ($urandom_range(0, 9) == 0) ? 32'($urandom)
                                           : 32'(1000 + $urandom_range(0, 100) - 50);
    if (t.mode)
      t.amount = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 40));
    else
      t.amount = ($urandom_range(0, 19) == 0) ? 31'($urandom) : 31'($urandom_range(1, 20));
    t.rows = -1;
    return t;
  endfunction

  // Receiver stall pattern: always ready, coin flip, or one cycle in four
  always @(posedge clk) begin
    ready_tick <= ready_tick + 1;
    if (ready_tick % 300 == 299) ready_mode <= $urandom_range(0, 2);
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom);
      default: out_ready <= (ready_tick % 4 == 0);
    endcase
  end

  // Check each row transaction against the oldest expectation
  always @(negedge clk) begin
    fill_row_t x;
    if (!rst && out_valid && out_ready) begin
      if (pending_rows.size() == 0) begin
        $display("%0t: unexpected row id %0d exch %0d", $time, report_order_id,
                 report_exchange);
        errors++;
      end else begin
        x = pending_rows.pop_front();
        if (report_order_id !== x.id) begin
          $display("%0t: report_order_id exp %0d act %0d", $time, x.id, report_order_id);
          errors++;
        end
        if (report_symbol !== x.sym) begin
          $display("%0t: report_symbol exp %0d act %0d", $time, x.sym, report_symbol);
          errors++;
        end
        if (report_exchange !== x.exch) begin
          $display("%0t: report_exchange exp %0d act %0d", $time, x.exch, report_exchange);
          errors++;
        end
        if (filled_quantity !== x.qty) begin
          $display("%0t: filled_quantity exp %0d act %0d", $time, x.qty, filled_quantity);
          errors++;
        end
        if (filled_notional !== x.notional) begin
          $display("%0t: filled_notional exp %0d act %0d", $time, x.notional,
                   filled_notional);
          errors++;
        end
        if (last !== x.last) begin
          $display("%0t: last exp %0d act %0d", $time, x.last, last);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(negedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Directed cases: empty book, zero-quantity order, crossing rules, arrival order
  order_txn_t directed [] = '{
    '{1'b1, 1'b0, 8'd0,   2'd0, 31'd0,          32'd0,          31'd5,          0},
    '{1'b0, 1'b0, 8'd5,   2'd0, 31'h7FFF_FFFF,  32'hFFFF_FFFF,  31'd0,          0},
    '{1'b1, 1'b0, 8'd5,   2'd3, 31'd0,          32'd0,          31'h7FFF_FFFF,  4},
    '{1'b1, 1'b0, 8'd5,   2'd3, 31'd0,          32'd0,          31'h7FFF_FFFF,  0},
    '{1'b0, 1'b1, 8'd255, 2'd0, 31'd1,          32'd100,        31'd10,         0},
    '{1'b1, 1'b1, 8'd255, 2'd0, 31'd0,          32'd99,         31'd5,          0},
    '{1'b1, 1'b1, 8'd255, 2'd1, 31'd0,          32'd100,        31'd4,          0},
    '{1'b1, 1'b1, 8'd255, 2'd2, 31'd0,          32'hFFFF_FFFF,  31'h7FFF_FFFF,  0},
    '{1'b1, 1'b1, 8'd255, 2'd0, 31'd0,          32'd0,          31'd0,          -1},
    '{1'b0, 1'b0, 8'd7,   2'd0, 31'd20,         32'd50,         31'd3,          0},
    '{1'b0, 1'b0, 8'd7,   2'd0, 31'd21,         32'd60,         31'd3,          0},
    '{1'b1, 1'b0, 8'd7,   2'd3, 31'd0,          32'd55,         31'd4,          0},
    '{1'b1, 1'b0, 8'd7,   2'd0, 31'd0,          32'd0,          31'd0,          -1},
    '{1'b0, 1'b1, 8'd7,   2'd0, 31'd22,         32'd10,         31'd1,          0},
    '{1'b1, 1'b0, 8'd7,   2'd1, 31'd0,          32'd0,          31'd100,        0},
    '{1'b1, 1'b0, 8'd7,   2'd0, 31'd0,          32'd0,          31'd0,          -1},
    '{1'b1, 1'b1, 8'd7,   2'd0, 31'd0,          32'd10,         31'd1,          0},
    '{1'b1, 1'b1, 8'd7,   2'd2, 31'd0,          32'd0,          31'd0,          -1}
  };

  initial begin
    int burst;
    book_count = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_order(directed[i]);

    // Random part in bursts with random gaps
    burst = 0;
    for (int i = 0; i < RandItems; i++) begin
      if (i == RandItems / 2) begin
        // hold the sender until every queued row has drained
        in_valid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge clk);
      end
      if (burst == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst = $urandom_range(1, 10);
      end
      send_order(random_order());
      burst--;
    end
    in_valid <= 1'b0;

    // Drain, then let the block settle
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && pending_rows.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/qdof_pkg.sv
hw/rtl/qdof_ctrl.sv
hw/rtl/qdof_dp.sv
hw/rtl/quote_driven_order_fill.sv
hw/rtl/qdof_chk.sv
tb/sv/tb.sv
